[src/slseq_pkg.sv]
// ----------------------------------------------------------------------------
// slseq_pkg
// shared types, constants and the control program of the step light sequencer
// ----------------------------------------------------------------------------
package slseq_pkg;

    localparam int STEPS       = 16;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int LVL_W       = 3;
    localparam int ECHO_W      = 13;
    localparam int ECHO_LIM_W  = ECHO_W + 1;
    localparam int TIME_W      = 32;
    localparam int PWM_W       = 12;
    localparam int PROD_W      = PWM_W + LVL_W;
    localparam int HOLD_W      = 16;
    localparam int LIM_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ECHO_PER_CM = 58;
    localparam int PWM_MAX     = 4095;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
    localparam logic [LVL_W-1:0]  CLOSING   = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWILIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd4;

    // register reset values
    localparam logic [LIM_W-1:0]  NEAR_LIMIT_RST = 7'd30;
    localparam logic [LVL_W-1:0]  TWILIGHT_RST   = 3'd2;
    localparam logic [LVL_W-1:0]  FULL_RST       = 3'd4;
    localparam logic [PWM_W-1:0]  PWM_STEP_RST   = 12'd1023;
    localparam logic [HOLD_W-1:0] HOLD_RST       = 16'd4000;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        MODE_POLL = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_PREP,
        OP_POLL,
        OP_EMIT_RST,
        OP_NOP,
        OP_BLINK,
        OP_RAMP,
        OP_EMIT,
        OP_ADVANCE,
        OP_ENDS_HI,
        OP_ENDS_LO,
        OP_FINISH
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NACC,
        C_ANIM,
        C_NORESET,
        C_NOGO,
        C_CLOSING,
        C_OUT_BUSY,
        C_EMIT_BUSY
    } t_cond_sel;

    localparam int UPC_W     = 4;
    localparam int UCODE_LEN = 14;

    localparam logic [UPC_W-1:0] UA_IDLE    = UPC_W'(0);
    localparam logic [UPC_W-1:0] UA_PREP    = UPC_W'(1);
    localparam logic [UPC_W-1:0] UA_POLL    = UPC_W'(2);
    localparam logic [UPC_W-1:0] UA_RST     = UPC_W'(3);
    localparam logic [UPC_W-1:0] UA_CHECK   = UPC_W'(4);
    localparam logic [UPC_W-1:0] UA_FRAME   = UPC_W'(5);
    localparam logic [UPC_W-1:0] UA_BLINK   = UPC_W'(6);
    localparam logic [UPC_W-1:0] UA_RAMP    = UPC_W'(7);
    localparam logic [UPC_W-1:0] UA_EMIT    = UPC_W'(8);
    localparam logic [UPC_W-1:0] UA_ADV     = UPC_W'(9);
    localparam logic [UPC_W-1:0] UA_CLOSE   = UPC_W'(10);
    localparam logic [UPC_W-1:0] UA_ENDS_LO = UPC_W'(11);
    localparam logic [UPC_W-1:0] UA_EMIT_C  = UPC_W'(12);
    localparam logic [UPC_W-1:0] UA_FINISH  = UPC_W'(13);

    typedef struct packed {
        t_op              op;
        t_cond_sel        cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic in_acc;
        logic anim;
        logic reset_req;
        logic go;
        logic closing;
        logic out_busy;
        logic emit_busy;
    } t_flags;

    // control program
    function automatic t_uword ucode(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: UA_IDLE};
        case (addr)
            UA_IDLE:    w = '{op: OP_IDLE,     cond: C_NACC,      target: UA_IDLE};
            UA_PREP:    w = '{op: OP_PREP,     cond: C_ANIM,      target: UA_FRAME};
            UA_POLL:    w = '{op: OP_POLL,     cond: C_NORESET,   target: UA_CHECK};
            UA_RST:     w = '{op: OP_EMIT_RST, cond: C_OUT_BUSY,  target: UA_RST};
            UA_CHECK:   w = '{op: OP_NOP,      cond: C_NOGO,      target: UA_IDLE};
            UA_FRAME:   w = '{op: OP_NOP,      cond: C_CLOSING,   target: UA_CLOSE};
            UA_BLINK:   w = '{op: OP_BLINK,    cond: C_NEVER,     target: UA_IDLE};
            UA_RAMP:    w = '{op: OP_RAMP,     cond: C_NEVER,     target: UA_IDLE};
            UA_EMIT:    w = '{op: OP_EMIT,     cond: C_EMIT_BUSY, target: UA_EMIT};
            UA_ADV:     w = '{op: OP_ADVANCE,  cond: C_ALWAYS,    target: UA_IDLE};
            UA_CLOSE:   w = '{op: OP_ENDS_HI,  cond: C_NEVER,     target: UA_IDLE};
            UA_ENDS_LO: w = '{op: OP_ENDS_LO,  cond: C_NEVER,     target: UA_IDLE};
            UA_EMIT_C:  w = '{op: OP_EMIT,     cond: C_EMIT_BUSY, target: UA_EMIT_C};
            UA_FINISH:  w = '{op: OP_FINISH,   cond: C_ALWAYS,    target: UA_IDLE};
            default:    w = '{op: OP_NOP,      cond: C_ALWAYS,    target: UA_IDLE};
        endcase
        return w;
    endfunction

    // wrap-around time compare
    function automatic logic is_past(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] d;
        d = now - t;
        return (d != '0) && !d[TIME_W-1];
    endfunction

endpackage

[src/slseq_sequencer.sv]
// ----------------------------------------------------------------------------
// slseq_sequencer
// step counter and program table; issues one control word per cycle
// ----------------------------------------------------------------------------
module slseq_sequencer
    import slseq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_op    o_op
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           w_word;
    logic             w_take;

    assign w_word = ucode(r_upc);
    assign o_op   = w_word.op;

    always_comb begin
        case (w_word.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NACC:      w_take = !i_flags.in_acc;
            C_ANIM:      w_take = i_flags.anim;
            C_NORESET:   w_take = !i_flags.reset_req;
            C_NOGO:      w_take = !i_flags.go;
            C_CLOSING:   w_take = i_flags.closing;
            C_OUT_BUSY:  w_take = i_flags.out_busy;
            C_EMIT_BUSY: w_take = i_flags.emit_busy;
            default:     w_take = 1'b1;
        endcase
        n_upc = w_take ? w_word.target : r_upc + UPC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    a_upc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc < UPC_W'(UCODE_LEN))
        else $error("step counter left the program");

    a_accept_leads_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UA_IDLE && i_flags.in_acc) |=> (r_upc == UA_PREP))
        else $error("accepted transaction not dispatched");

endmodule

[src/slseq_datapath.sv]
// ----------------------------------------------------------------------------
// slseq_datapath
// configuration, sequencer state, step levels and the result register
// ----------------------------------------------------------------------------
module slseq_datapath
    import slseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ECHO_W-1:0]     i_echo_bottom_us,
    input  logic [ECHO_W-1:0]     i_echo_top_us,
    input  logic [TIME_W-1:0]     i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_kind,
    output logic [STEP_W-1:0]     o_channel,
    output logic [PWM_W-1:0]      o_pwm_value,
    output logic                  o_reset_bottom,
    output logic                  o_reset_top,
    output logic                  o_last_item,
    input  t_op                   i_op,
    output t_flags                o_flags
);

    // configuration
    logic [LIM_W-1:0]  r_near_limit;
    logic [LVL_W-1:0]  r_twilight;
    logic [LVL_W-1:0]  r_full;
    logic [PWM_W-1:0]  r_pwm_step;
    logic [HOLD_W-1:0] r_hold;

    // latched transaction
    logic [ECHO_W-1:0] r_echo_b;
    logic [ECHO_W-1:0] r_echo_t;
    logic [TIME_W-1:0] r_now;

    // sequencer state
    t_dir              r_dir;
    t_mode             r_mode;
    logic [TIME_W-1:0] r_deadline;
    logic [TIME_W-1:0] r_half_t;
    logic [STEP_W-1:0] r_step;
    logic [LVL_W-1:0]  r_frame;
    logic              r_blink;
    logic              r_go;
    logic              r_rst_b;
    logic              r_rst_t;
    logic [STEP_W-1:0] r_cnt;
    logic [LVL_W-1:0]  r_levels [STEPS];

    // result register
    logic              r_out_valid;
    logic              r_out_kind;
    logic [STEP_W-1:0] r_out_channel;
    logic [PWM_W-1:0]  r_out_pwm;
    logic              r_out_rb;
    logic              r_out_rt;
    logic              r_out_last;

    logic                  w_in_acc;
    logic                  w_slot_free;
    logic                  w_rising;
    logic                  w_up;
    logic [STEP_W-1:0]     w_tgt;
    logic [STEP_W-1:0]     w_far;
    logic [STEP_W-1:0]     w_rd_addr;
    logic [LVL_W-1:0]      w_rd_lv;
    logic                  w_wr_en;
    logic [STEP_W-1:0]     w_wr_addr;
    logic [LVL_W-1:0]      w_wr_data;
    logic [PROD_W-1:0]     w_prod;
    logic [PWM_W-1:0]      w_pwm;
    logic [ECHO_LIM_W-1:0] w_lim_echo;
    logic                  w_bot_zero;
    logic                  w_top_zero;
    logic                  w_tb;
    logic                  w_tt;
    logic                  w_trig;
    t_dir                  w_want;
    logic                  w_finished;
    logic                  w_half_gone;
    logic                  w_start;
    logic                  w_ramp_down;
    logic [TIME_W-1:0]     w_hold_end;
    logic [HOLD_W-1:0]     w_half_hold;
    logic [LVL_W-1:0]      w_per_step;
    logic [LVL_W:0]        w_next_frame;

    assign o_in_ready  = (i_op == OP_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign w_rising  = (r_mode == MODE_UP);
    assign w_up      = (r_dir == DIR_UP);
    assign w_tgt     = w_up ? r_step : LAST_STEP - r_step;
    assign w_far     = (w_rising == w_up) ? LAST_STEP : '0;
    assign w_rd_addr = (i_op == OP_EMIT) ? r_cnt : w_tgt;
    assign w_rd_lv   = r_levels[w_rd_addr];

    assign w_prod = PROD_W'(w_rd_lv) * PROD_W'(r_pwm_step);
    assign w_pwm  = (w_prod > PROD_W'(PWM_MAX)) ? PWM_W'(PWM_MAX) : w_prod[PWM_W-1:0];

    // distance test without a divider: d = echo/58
    assign w_lim_echo  = (ECHO_LIM_W'(r_near_limit) + ECHO_LIM_W'(1))
                         * ECHO_LIM_W'(ECHO_PER_CM);
    assign w_bot_zero  = (r_echo_b < ECHO_W'(ECHO_PER_CM));
    assign w_top_zero  = (r_echo_t < ECHO_W'(ECHO_PER_CM));
    assign w_tb        = !w_bot_zero && (ECHO_LIM_W'(r_echo_b) < w_lim_echo);
    assign w_tt        = !w_top_zero && (ECHO_LIM_W'(r_echo_t) < w_lim_echo);
    assign w_trig      = w_tb || w_tt;
    assign w_want      = w_tt ? DIR_DOWN : DIR_UP;
    assign w_finished  = is_past(r_now, r_deadline);
    assign w_half_gone = is_past(r_now, r_half_t);
    assign w_start     = w_trig && (r_dir == DIR_NONE);
    assign w_ramp_down = !w_trig && w_finished && (r_dir != DIR_NONE);
    assign w_hold_end  = r_now + TIME_W'(r_hold);
    assign w_half_hold = r_hold - (r_hold >> 1);

    assign w_per_step   = (r_full != '0) ? r_full : LVL_W'(1);
    assign w_next_frame = (LVL_W + 1)'(r_frame) + (LVL_W + 1)'(1);

    // single write port into the step levels
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_tgt;
        w_wr_data = w_rd_lv;
        unique case (i_op)
            OP_BLINK: begin
                if (r_frame == '0 && !r_step[0]) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_far;
                    w_wr_data = r_blink ? r_twilight : '0;
                end
            end
            OP_RAMP: begin
                if (r_frame < r_full) begin
                    if (w_rising) begin
                        w_wr_en   = (w_rd_lv < r_full);
                        w_wr_data = w_rd_lv + LVL_W'(1);
                    end else begin
                        w_wr_en   = (w_rd_lv != '0);
                        w_wr_data = w_rd_lv - LVL_W'(1);
                    end
                end
            end
            OP_ENDS_HI: begin
                w_wr_en   = 1'b1;
                w_wr_addr = LAST_STEP;
                w_wr_data = r_twilight;
            end
            OP_ENDS_LO: begin
                w_wr_en   = !w_up;
                w_wr_addr = '0;
                w_wr_data = r_twilight;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STEPS; k++) begin
                r_levels[k] <= '0;
            end
            r_levels[0]         <= TWILIGHT_RST;
            r_levels[STEPS - 1] <= TWILIGHT_RST;
        end else if (w_wr_en) begin
            r_levels[w_wr_addr] <= w_wr_data;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_limit <= NEAR_LIMIT_RST;
            r_twilight   <= TWILIGHT_RST;
            r_full       <= FULL_RST;
            r_pwm_step   <= PWM_STEP_RST;
            r_hold       <= HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NEAR_LIMIT: r_near_limit <= i_cfg_wdata[LIM_W-1:0];
                CFG_TWILIGHT:   r_twilight   <= i_cfg_wdata[LVL_W-1:0];
                CFG_FULL:       r_full       <= i_cfg_wdata[LVL_W-1:0];
                CFG_PWM_STEP:   r_pwm_step   <= i_cfg_wdata[PWM_W-1:0];
                CFG_HOLD:       r_hold       <= i_cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_echo_b <= i_echo_bottom_us;
            r_echo_t <= i_echo_top_us;
            r_now    <= i_now_ms;
        end
        if (i_op == OP_PREP) begin
            r_half_t <= r_deadline - TIME_W'(w_half_hold);
            r_rst_b  <= w_bot_zero;
            r_rst_t  <= w_top_zero;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= DIR_NONE;
            r_mode     <= MODE_POLL;
            r_deadline <= '0;
            r_step     <= '0;
            r_frame    <= '0;
            r_blink    <= 1'b0;
            r_go       <= 1'b0;
        end else begin
            unique case (i_op)
                OP_POLL: begin
                    r_go <= w_start || w_ramp_down;
                    if (w_trig) begin
                        if (r_dir == DIR_NONE) begin
                            r_dir   <= w_want;
                            r_mode  <= MODE_UP;
                            r_step  <= '0;
                            r_frame <= '0;
                            r_blink <= 1'b0;
                        end else if (r_dir == w_want) begin
                            r_deadline <= w_hold_end;
                        end else if (w_half_gone) begin
                            r_dir      <= w_want;
                            r_deadline <= w_hold_end;
                        end
                    end else if (w_ramp_down) begin
                        r_mode  <= MODE_DOWN;
                        r_step  <= '0;
                        r_frame <= '0;
                        r_blink <= 1'b0;
                    end
                end
                OP_ADVANCE: begin
                    if (w_next_frame >= (LVL_W + 1)'(w_per_step)) begin
                        r_frame <= '0;
                        if (!r_step[0]) begin
                            r_blink <= !r_blink;
                        end
                        if (r_step == LAST_STEP) begin
                            r_frame <= CLOSING;
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end else begin
                        r_frame <= w_next_frame[LVL_W-1:0];
                    end
                end
                OP_FINISH: begin
                    if (w_rising) begin
                        r_deadline <= w_hold_end;
                    end else begin
                        r_dir <= DIR_NONE;
                    end
                    r_mode  <= MODE_POLL;
                    r_step  <= '0;
                    r_frame <= '0;
                    r_blink <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // result register and emit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (w_slot_free) begin
                r_out_valid <= 1'b0;
            end
            if (w_slot_free && i_op == OP_EMIT_RST) begin
                r_out_valid <= 1'b1;
            end
            if (w_slot_free && i_op == OP_EMIT) begin
                r_out_valid <= 1'b1;
                r_cnt       <= (r_cnt == LAST_STEP) ? '0 : r_cnt + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && i_op == OP_EMIT_RST) begin
            r_out_kind    <= 1'b1;
            r_out_channel <= '0;
            r_out_pwm     <= '0;
            r_out_rb      <= r_rst_b;
            r_out_rt      <= r_rst_t;
            r_out_last    <= !r_go;
        end else if (w_slot_free && i_op == OP_EMIT) begin
            r_out_kind    <= 1'b0;
            r_out_channel <= r_cnt;
            r_out_pwm     <= w_pwm;
            r_out_rb      <= 1'b0;
            r_out_rt      <= 1'b0;
            r_out_last    <= (r_cnt == LAST_STEP);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_channel      = r_out_channel;
    assign o_pwm_value    = r_out_pwm;
    assign o_reset_bottom = r_out_rb;
    assign o_reset_top    = r_out_rt;
    assign o_last_item    = r_out_last;

    assign o_flags.in_acc    = w_in_acc;
    assign o_flags.anim      = (r_mode != MODE_POLL);
    assign o_flags.reset_req = r_rst_b || r_rst_t;
    assign o_flags.go        = r_go;
    assign o_flags.closing   = (r_frame == CLOSING);
    assign o_flags.out_busy  = !w_slot_free;
    assign o_flags.emit_busy = !w_slot_free || (r_cnt != LAST_STEP);

    a_cnt_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_IDLE) |-> (r_cnt == '0))
        else $error("emit counter not rewound between transactions");

    a_poll_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_POLL) |-> (r_step == '0 && r_frame == '0))
        else $error("ramp position left over in polling mode");

    a_closing_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame == CLOSING) |-> (r_step == LAST_STEP && r_mode != MODE_POLL))
        else $error("closing frame before the last step");

    a_ramp_has_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_POLL) |-> (r_dir != DIR_NONE))
        else $error("ramp running without a travel direction");

endmodule

[src/stair_light_sequencer.sv]
// ----------------------------------------------------------------------------
// stair_light_sequencer
// sonar-triggered step light ramps, driven by a small control program
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) takes one transaction with both
//   sonar echo widths and the millisecond time; output channel (o_out_valid /
//   i_out_ready) returns 0 to 17 results per transaction, o_last_item marking
//   the final one. the user writes registers on the plain port i_cfg_we /
//   i_cfg_idx / i_cfg_wdata only while the block is idle (not enforced).
// timing:
//   a polling transaction runs the prepare, poll, optional reset result and
//   check steps before the next accept; the 16 channel results of an
//   animation frame leave the single result register one per cycle while
//   the receiver takes them; a ramp's first frame follows its starting poll.
// reset:
//   synchronous, active low; registers return to their defaults, the end
//   steps to the twilight level, the sequencer to polling.
// stall:
//   a held result stays in the result register; the program waits on its
//   emit step and resumes when the receiver takes it.
// ----------------------------------------------------------------------------
module stair_light_sequencer
    import slseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ECHO_W-1:0]     i_echo_bottom_us,
    input  logic [ECHO_W-1:0]     i_echo_top_us,
    input  logic [TIME_W-1:0]     i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_kind,
    output logic [STEP_W-1:0]     o_channel,
    output logic [PWM_W-1:0]      o_pwm_value,
    output logic                  o_reset_bottom,
    output logic                  o_reset_top,
    output logic                  o_last_item
);

    t_op    w_op;
    t_flags w_flags;

    slseq_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op)
    );

    slseq_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_echo_bottom_us (i_echo_bottom_us),
        .i_echo_top_us    (i_echo_top_us),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_channel        (o_channel),
        .o_pwm_value      (o_pwm_value),
        .o_reset_bottom   (o_reset_bottom),
        .o_reset_top      (o_reset_top),
        .o_last_item      (o_last_item),
        .i_op             (w_op),
        .o_flags          (w_flags)
    );

endmodule
